// ===== hdl/suq_pkg.sv =====
package suq_pkg;

	// fixed field widths of one beat
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 5;

	// operation codes
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic compare;
		logic update;
	} suq_cmd_t;

endpackage

// ===== hdl/suq_ctrl.sv =====
module suq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output suq_pkg::suq_cmd_t cmd
);
	import suq_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CMP  = 4'b0010,
		ST_UPD  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_nxt = ST_CMP;
			end
			ST_CMP:  state_nxt = ST_UPD;
			ST_UPD:  state_nxt = ST_DONE;
			ST_DONE: state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nxt;
	end

	// commands and handshake
	assign cmd.load    = (state_q == ST_IDLE) && start;
	assign cmd.compare = (state_q == ST_CMP);
	assign cmd.update  = (state_q == ST_UPD);
	assign busy        = (state_q != ST_IDLE);
	assign done        = (state_q == ST_DONE);

endmodule

// ===== hdl/suq_datapath.sv =====
module suq_datapath #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  suq_pkg::suq_cmd_t                   cmd,
	input  logic                                func,
	input  logic signed [suq_pkg::VALUE_W-1:0]  value,
	output logic        [suq_pkg::COUNT_W-1:0]  count,
	output logic signed [suq_pkg::VALUE_W-1:0]  smallest,
	output logic                                is_empty,
	output logic                                dropped
);
	import suq_pkg::*;

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic                     func_q;
	logic signed [VALUE_W-1:0] value_q;
	logic signed [VALUE_W-1:0] cell_q [DEPTH];
	logic [DEPTH-1:0]          valid_q;
	logic [DEPTH-1:0]          lt_q;
	logic [DEPTH-1:0]          eq_q;
	logic [CNT_W-1:0]          count_q;
	logic                      drop_q;

	logic dup;
	logic full;
	logic do_push;
	logic do_pop;

	// capture the input beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			value_q <= value;
		end
	end

	// insert decision from registered compares
	assign dup     = |eq_q;
	assign full    = (count_q == CNT_W'(DEPTH));
	assign do_push = cmd.update && (func_q == FUNC_PUSH) && !dup && !full;
	assign do_pop  = cmd.update && (func_q == FUNC_POP) && (count_q != '0);

	// one cell per slot: parallel compare, then shift by one
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [VALUE_W-1:0] up_val;
		logic                      up_ins;
		logic                      up_vld;
		logic signed [VALUE_W-1:0] dn_val;
		logic                      dn_vld;

		// neighbor below feeds a push shift
		if (i == 0) begin : g_first
			assign up_val = value_q;
			assign up_ins = 1'b1;
			assign up_vld = 1'b1;
		end else begin : g_rest
			assign up_val = lt_q[i-1] ? value_q : cell_q[i-1];
			assign up_ins = 1'b1;
			assign up_vld = 1'b1 & (valid_q[i-1] | valid_q[i]);
		end

		// neighbor above feeds a pop shift
		if (i == DEPTH - 1) begin : g_last
			assign dn_val = cell_q[i];
			assign dn_vld = 1'b0;
		end else begin : g_mid
			assign dn_val = cell_q[i+1];
			assign dn_vld = valid_q[i+1];
		end

		// compare against the incoming value
		always_ff @(posedge clk) begin
			if (cmd.compare) begin
				lt_q[i] <= valid_q[i] && (cell_q[i] < value_q);
				eq_q[i] <= valid_q[i] && (cell_q[i] == value_q);
			end
		end

		// slot value
		always_ff @(posedge clk) begin
			if (do_push && !lt_q[i] && up_ins) cell_q[i] <= up_val;
			else if (do_pop) cell_q[i] <= dn_val;
		end

		// slot valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) valid_q[i] <= 1'b0;
			else if (do_push) valid_q[i] <= up_vld;
			else if (do_pop) valid_q[i] <= dn_vld;
		end
	end

	// held count and drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else if (do_push) count_q <= count_q + CNT_W'(1);
		else if (do_pop) count_q <= count_q - CNT_W'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.update) drop_q <= (func_q == FUNC_PUSH) && !dup && full;
	end

	// result beat
	assign count    = COUNT_W'(count_q);
	assign is_empty = (count_q == '0);
	assign smallest = is_empty ? '0 : cell_q[0];
	assign dropped  = drop_q;

endmodule

// ===== hdl/sorted_unique_min_queue.sv =====
// sorted set of distinct signed values, smallest first, with push and pop
// the result strobe rises in ST_DONE, after the ST_CMP and ST_UPD steps
// a new item is taken only back in idle, after the compare, update and
// result steps of the controller; busy stays high for the whole item
// reset: arst_n clears the controller, slot valid bits and count at once
// the receiver cannot stall: each result is shown for one cycle with done
module sorted_unique_min_queue #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                func,
	input  logic signed [suq_pkg::VALUE_W-1:0]  value,
	output logic                                done,
	output logic        [suq_pkg::COUNT_W-1:0]  count,
	output logic signed [suq_pkg::VALUE_W-1:0]  smallest,
	output logic                                is_empty,
	output logic                                dropped
);
	import suq_pkg::*;

	suq_cmd_t cmd;

	// sequencer
	suq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// slot array
	suq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.func     (func),
		.value    (value),
		.count    (count),
		.smallest (smallest),
		.is_empty (is_empty),
		.dropped  (dropped)
	);

`ifndef NO_ASSERTIONS
	// an accepted beat makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");

	// a result beat follows each acceptance, after the compare and update steps
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##3 done)
		else $error("result beat missing after accept");

	// one result beat per item
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat repeated");

	// an empty set reports zero as smallest and never drops
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_empty |-> smallest == '0 && !dropped)
		else $error("empty result carries data");
`endif

endmodule
